@@ hw/rtl/swm_pkg.sv @@
package swm_pkg;

	localparam int CFG_W = 7;
	localparam int AGE_OUT_W = 6;

	typedef struct packed {
		logic step;
		logic shift;
		logic clear;
	} ctrl_t;

endpackage

@@ hw/rtl/swm_cell.sv @@
module swm_cell #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int AW = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swm_pkg::ctrl_t          ctrl,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	input  logic                    left_keep,
	input  logic                    right_vld,
	input  logic [SAMPLE_WIDTH-1:0] right_val,
	input  logic [AW-1:0]           right_age,
	output logic                    keep,
	output logic                    vld,
	output logic [SAMPLE_WIDTH-1:0] val,
	output logic [AW-1:0]           age,
	output logic                    vld_d,
	output logic [SAMPLE_WIDTH-1:0] val_d,
	output logic [AW-1:0]           age_d
);
	import swm_pkg::*;

	logic                    vld_q;
	logic [SAMPLE_WIDTH-1:0] val_q;
	logic [AW-1:0]           age_q;
	logic                    src_vld;
	logic [SAMPLE_WIDTH-1:0] src_val;
	logic [AW-1:0]           src_age;
	logic                    take;

	// The source is this cell, or its right neighbor when the front entry leaves.
	always_comb begin
		src_vld = (ctrl.shift ? right_vld : vld_q) && !ctrl.clear;
		src_val = ctrl.shift ? right_val : val_q;
		src_age = ctrl.shift ? right_age : age_q;
		keep    = src_vld && ($signed(src_val) > $signed(sample));
		take    = !keep && left_keep;
		if (ctrl.step) begin
			vld_d = keep || take;
			val_d = keep ? src_val : sample;
			age_d = keep ? src_age + AW'(1) : '0;
		end else begin
			vld_d = src_vld;
			val_d = src_val;
			age_d = src_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.step || ctrl.shift) begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step || ctrl.shift) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

	assign vld = vld_q;
	assign val = val_q;
	assign age = age_q;

endmodule

@@ hw/rtl/sliding_window_maximum.sv @@
// A result beat appears in the cycle after an accepted sample completes a full
// window. Throughput: one sample per cycle unless the output stalls; after a
// shrink, stale front entries drain from the cell chain before samples resume.
// Reset clears the cell valid bits, the sample count and the output valid flag,
// and sets the window size to one.
module sliding_window_maximum #(
	parameter int MAX_WINDOW = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: sample.
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	// Fields from bit 0: new_sequence.
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0: window_max, max_age.
	output logic [((SAMPLE_WIDTH+6+7)/8)*8-1:0] m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]           cfg_data
);
	import swm_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (AW > CFG_W) ? AW : CFG_W;
	localparam int OUT_W = ((SAMPLE_WIDTH + 6 + 7) / 8) * 8;

	logic [CFG_W-1:0]        window_q;
	logic [AW-1:0]           seen_q;
	logic                    m_valid_q;
	logic [SAMPLE_WIDTH-1:0] max_q;
	logic [AGE_OUT_W-1:0]    age_out_q;

	logic [CW-1:0]           win_ext;
	logic [AW-1:0]           win;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic                    drain;
	logic                    step;
	logic [AW:0]             seen_sum;
	logic [AW:0]             front_age_inc;
	logic [AW-1:0]           seen_nx;
	logic                    emit;
	ctrl_t                   ctrl;

	logic                    keep  [MAX_WINDOW];
	logic                    vld   [MAX_WINDOW+1];
	logic [SAMPLE_WIDTH-1:0] val   [MAX_WINDOW+1];
	logic [AW-1:0]           age   [MAX_WINDOW+1];
	logic                    vld_d [MAX_WINDOW];
	logic [SAMPLE_WIDTH-1:0] val_d [MAX_WINDOW];
	logic [AW-1:0]           age_d [MAX_WINDOW];

	assign cfg_ready = 1'b1;
	assign sample = s_axis_tdata[SAMPLE_WIDTH-1:0];

	always_comb begin
		win_ext = CW'(window_q);
		if (window_q == '0) begin
			win = AW'(1);
		end else if (win_ext > CW'(MAX_WINDOW)) begin
			win = AW'(MAX_WINDOW);
		end else begin
			win = AW'(win_ext);
		end
	end

	// A front entry that is already outside a shrunk window is drained first.
	assign drain = vld[0] && (age[0] >= win);
	assign s_axis_tready = !drain && (!m_valid_q || m_axis_tready);
	assign step = s_axis_tvalid && s_axis_tready;
	assign front_age_inc = {1'b0, age[0]} + (AW+1)'(1);

	always_comb begin
		ctrl.step  = step;
		ctrl.clear = step && s_axis_tuser;
		ctrl.shift = drain
			|| (step && !s_axis_tuser && vld[0] && (front_age_inc >= {1'b0, win}));
	end

	always_comb begin
		seen_sum = {1'b0, seen_q} + (AW+1)'(1);
		if (s_axis_tuser) begin
			seen_nx = AW'(1);
		end else if (seen_sum >= {1'b0, win}) begin
			seen_nx = win;
		end else begin
			seen_nx = seen_sum[AW-1:0];
		end
		emit = (seen_nx == win);
	end

	assign vld[MAX_WINDOW] = 1'b0;
	assign val[MAX_WINDOW] = '0;
	assign age[MAX_WINDOW] = '0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.AW(AW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.sample(sample),
			.left_keep((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
			.right_vld(vld[i+1]),
			.right_val(val[i+1]),
			.right_age(age[i+1]),
			.keep(keep[i]),
			.vld(vld[i]),
			.val(val[i]),
			.age(age[i]),
			.vld_d(vld_d[i]),
			.val_d(val_d[i]),
			.age_d(age_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= CFG_W'(1);
			seen_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (step) begin
				seen_q    <= seen_nx;
				m_valid_q <= emit;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			max_q     <= val_d[0];
			age_out_q <= AGE_OUT_W'(age_d[0]);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'({age_out_q, max_q});

endmodule
